/* src/mtxr_pkg.sv */
// ----------------------------------------------------------------------------
// mtxr_pkg
// Shared types and constants of the mesh/torus XY route decider: channel
// payloads, action codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package mtxr_pkg;

	localparam int unsigned ID_BITS             = 16;
	localparam int unsigned GRID_BITS           = 9;
	localparam int unsigned HOP_BITS            = 16;
	localparam int unsigned DIST_BITS           = 16;
	localparam int unsigned CFG_IDX_BITS        = 3;
	localparam int unsigned CFG_DATA_BITS       = 16;
	localparam int unsigned DIV_STEPS_PER_STAGE = 4;

	localparam logic [ID_BITS-1:0]   SELF_NODE_RESET   = 16'd0;
	localparam logic [GRID_BITS-1:0] GRID_WIDTH_RESET  = 9'd4;
	localparam logic [GRID_BITS-1:0] GRID_HEIGHT_RESET = 9'd4;
	localparam logic                 TORUS_MODE_RESET  = 1'b0;
	localparam logic [HOP_BITS-1:0]  HOP_LIMIT_RESET   = 16'd64;

	typedef enum logic [2:0] {
		ACT_LOCAL      = 3'd0,
		ACT_NORTH      = 3'd1,
		ACT_SOUTH      = 3'd2,
		ACT_EAST       = 3'd3,
		ACT_WEST       = 3'd4,
		ACT_DROP_HOPS  = 3'd5,
		ACT_DROP_ROUTE = 3'd6
	} action_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SELF_NODE   = 3'd0,
		REG_GRID_WIDTH  = 3'd1,
		REG_GRID_HEIGHT = 3'd2,
		REG_TORUS_MODE  = 3'd3,
		REG_HOP_LIMIT   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic                req_type;
		logic [ID_BITS-1:0]  dest_id;
		logic [HOP_BITS-1:0] hops_taken;
	} req_t;

	typedef struct packed {
		action_t              action;
		logic [HOP_BITS-1:0]  new_hop_count;
		logic [DIST_BITS-1:0] hop_distance;
	} rsp_t;

	typedef struct packed {
		logic [CFG_IDX_BITS-1:0]  index;
		logic [CFG_DATA_BITS-1:0] data;
	} cfg_t;

	// Per-packet results settled at the input stage, carried alongside the divide.
	typedef struct packed {
		logic                drop_hops;
		logic                is_local;
		logic [HOP_BITS-1:0] new_hops;
	} side_t;

endpackage

`default_nettype wire

/* src/mtxr_stream_if.sv */
// ----------------------------------------------------------------------------
// mtxr_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtxr_stream_if #(
	parameter type payload_t = logic
);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

/* src/mtxr_div_stage.sv */
// ----------------------------------------------------------------------------
// mtxr_div_stage
// One register stage of the restoring divider that splits this node's id and
// the destination id into column (remainder) and row (quotient) by the width.
// ----------------------------------------------------------------------------
`default_nettype none

module mtxr_div_stage #(
	parameter int unsigned ID_W   = 16,
	parameter int unsigned GRID_W = 9,
	parameter int unsigned STEPS  = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [GRID_W-1:0]  divisor,
	input  logic               up_valid,
	output logic               up_ready,
	input  logic [GRID_W-1:0]  up_self_rem,
	input  logic [ID_W-1:0]    up_self_quo,
	input  logic [GRID_W-1:0]  up_dest_rem,
	input  logic [ID_W-1:0]    up_dest_quo,
	input  mtxr_pkg::side_t    up_side,
	output logic               dn_valid,
	input  logic               dn_ready,
	output logic [GRID_W-1:0]  dn_self_rem,
	output logic [ID_W-1:0]    dn_self_quo,
	output logic [GRID_W-1:0]  dn_dest_rem,
	output logic [ID_W-1:0]    dn_dest_quo,
	output mtxr_pkg::side_t    dn_side
);

	logic [GRID_W-1:0] self_rem_d;
	logic [ID_W-1:0]   self_quo_d;
	logic [GRID_W-1:0] dest_rem_d;
	logic [ID_W-1:0]   dest_quo_d;

	// The quotient word shifts left: dividend bits leave at the top and quotient
	// bits enter at the bottom.
	function automatic logic [GRID_W+ID_W-1:0] div_step(
		input logic [GRID_W-1:0] rem,
		input logic [ID_W-1:0]   quo,
		input logic [GRID_W-1:0] d
	);
		logic [GRID_W:0] t;
		logic            take;
		t    = {rem, quo[ID_W-1]};
		take = (t >= {1'b0, d});
		if (take) begin
			t = t - {1'b0, d};
		end
		return {t[GRID_W-1:0], quo[ID_W-2:0], take};
	endfunction

	always_comb begin
		self_rem_d = up_self_rem;
		self_quo_d = up_self_quo;
		dest_rem_d = up_dest_rem;
		dest_quo_d = up_dest_quo;
		for (int i = 0; i < int'(STEPS); i++) begin
			{self_rem_d, self_quo_d} = div_step(self_rem_d, self_quo_d, divisor);
			{dest_rem_d, dest_quo_d} = div_step(dest_rem_d, dest_quo_d, divisor);
		end
	end

	assign up_ready = !dn_valid || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid <= 1'b0;
		end else if (up_ready) begin
			dn_valid <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			dn_self_rem <= self_rem_d;
			dn_self_quo <= self_quo_d;
			dn_dest_rem <= dest_rem_d;
			dn_dest_quo <= dest_quo_d;
			dn_side     <= up_side;
		end
	end

endmodule

`default_nettype wire

/* src/mtxr_route.sv */
// ----------------------------------------------------------------------------
// mtxr_route
// Three register stages after the divide: raw offsets, ring-shortest offset
// selection with magnitudes, then distance, action and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtxr_route #(
	parameter int unsigned ID_W   = 16,
	parameter int unsigned GRID_W = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [GRID_W-1:0] width,
	input  logic [GRID_W-1:0] height,
	input  logic              torus,
	input  logic              up_valid,
	output logic              up_ready,
	input  logic [GRID_W-1:0] self_rem,
	input  logic [ID_W-1:0]   self_quo,
	input  logic [GRID_W-1:0] dest_rem,
	input  logic [ID_W-1:0]   dest_quo,
	input  mtxr_pkg::side_t   side,
	mtxr_stream_if.source     rsp
);

	localparam int unsigned XW = GRID_W + 2;
	localparam int unsigned YW = ((ID_W > GRID_W) ? ID_W : GRID_W) + 2;
	localparam int unsigned SW = ((YW + 1) > (mtxr_pkg::DIST_BITS + 1)) ?
		(YW + 1) : (mtxr_pkg::DIST_BITS + 1);

	logic en1, en2, en3;

	logic                   v_r1;
	logic signed [XW-1:0]   dx_r1;
	logic signed [YW-1:0]   dy_r1;
	mtxr_pkg::side_t        side_r1;

	logic                   v_r2;
	logic [XW-1:0]          ax_r2;
	logic [YW-1:0]          ay_r2;
	logic                   ox_pos_r2, ox_neg_r2, oy_pos_r2, oy_neg_r2;
	mtxr_pkg::side_t        side_r2;

	logic                   v_r3;
	mtxr_pkg::action_t      act_r3;
	logic [mtxr_pkg::HOP_BITS-1:0]  hops_r3;
	logic [mtxr_pkg::DIST_BITS-1:0] dist_r3;

	logic signed [XW-1:0] alt_x, sel_x, wx;
	logic signed [YW-1:0] alt_y, sel_y, hy;
	logic [XW-1:0]        abs_dx, abs_ax, ax_d;
	logic [YW-1:0]        abs_dy, abs_ay, ay_d;
	logic [SW-1:0]        sum;
	logic [mtxr_pkg::DIST_BITS-1:0] dist_d;
	mtxr_pkg::action_t    act_d;

	assign en3      = !v_r3 || rsp.ready;
	assign en2      = !v_r2 || en3;
	assign en1      = !v_r1 || en2;
	assign up_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r1 <= 1'b0;
			v_r2 <= 1'b0;
			v_r3 <= 1'b0;
		end else begin
			if (en1) begin
				v_r1 <= up_valid;
			end
			if (en2) begin
				v_r2 <= v_r1;
			end
			if (en3) begin
				v_r3 <= v_r2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && en1) begin
			dx_r1   <= $signed(XW'(dest_rem)) - $signed(XW'(self_rem));
			dy_r1   <= $signed(YW'(dest_quo)) - $signed(YW'(self_quo));
			side_r1 <= side;
		end
	end

	// In torus mode the way around the ring wins only when strictly shorter.
	always_comb begin
		wx     = $signed(XW'(width));
		hy     = $signed(YW'(height));
		alt_x  = (dx_r1 > 0) ? (dx_r1 - wx) : (dx_r1 + wx);
		alt_y  = (dy_r1 > 0) ? (dy_r1 - hy) : (dy_r1 + hy);
		abs_dx = (dx_r1 < 0) ? -dx_r1 : dx_r1;
		abs_ax = (alt_x < 0) ? -alt_x : alt_x;
		abs_dy = (dy_r1 < 0) ? -dy_r1 : dy_r1;
		abs_ay = (alt_y < 0) ? -alt_y : alt_y;
		if (torus && (abs_ax < abs_dx)) begin
			sel_x = alt_x;
			ax_d  = abs_ax;
		end else begin
			sel_x = dx_r1;
			ax_d  = abs_dx;
		end
		if (torus && (abs_ay < abs_dy)) begin
			sel_y = alt_y;
			ay_d  = abs_ay;
		end else begin
			sel_y = dy_r1;
			ay_d  = abs_dy;
		end
	end

	always_ff @(posedge clk) begin
		if (v_r1 && en2) begin
			ax_r2     <= ax_d;
			ay_r2     <= ay_d;
			ox_pos_r2 <= (sel_x > 0);
			ox_neg_r2 <= (sel_x < 0);
			oy_pos_r2 <= (sel_y > 0);
			oy_neg_r2 <= (sel_y < 0);
			side_r2   <= side_r1;
		end
	end

	always_comb begin
		sum    = SW'(ax_r2) + SW'(ay_r2);
		dist_d = (sum > SW'({mtxr_pkg::DIST_BITS{1'b1}})) ? '1 : sum[mtxr_pkg::DIST_BITS-1:0];
		priority if (side_r2.drop_hops) begin
			act_d = mtxr_pkg::ACT_DROP_HOPS;
		end else if (side_r2.is_local) begin
			act_d = mtxr_pkg::ACT_LOCAL;
		end else if (ox_pos_r2) begin
			act_d = mtxr_pkg::ACT_EAST;
		end else if (ox_neg_r2) begin
			act_d = mtxr_pkg::ACT_WEST;
		end else if (oy_pos_r2) begin
			act_d = mtxr_pkg::ACT_SOUTH;
		end else if (oy_neg_r2) begin
			act_d = mtxr_pkg::ACT_NORTH;
		end else begin
			act_d = mtxr_pkg::ACT_DROP_ROUTE;
		end
	end

	always_ff @(posedge clk) begin
		if (v_r2 && en3) begin
			act_r3  <= act_d;
			hops_r3 <= side_r2.new_hops;
			dist_r3 <= dist_d;
		end
	end

	assign rsp.valid                 = v_r3;
	assign rsp.payload.action        = act_r3;
	assign rsp.payload.new_hop_count = hops_r3;
	assign rsp.payload.hop_distance  = dist_r3;

	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		v_r3 && (act_r3 == mtxr_pkg::ACT_LOCAL || act_r3 == mtxr_pkg::ACT_DROP_ROUTE)
		|-> (dist_r3 == '0))
		else $error("Local or unroutable result with nonzero distance.");

	a_move_dist: assert property (@(posedge clk) disable iff (!arst_n)
		v_r3 && (act_r3 == mtxr_pkg::ACT_EAST || act_r3 == mtxr_pkg::ACT_WEST ||
		act_r3 == mtxr_pkg::ACT_NORTH || act_r3 == mtxr_pkg::ACT_SOUTH)
		|-> (dist_r3 != '0))
		else $error("Forwarded result with zero distance.");

	a_r2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_r2 && !en3 |=> v_r2 && $stable(ax_r2) && $stable(ay_r2))
		else $error("Offset stage lost its contents during a stall.");

endmodule

`default_nettype wire

/* src/mesh_torus_xy_route_decider.sv */
// ----------------------------------------------------------------------------
// mesh_torus_xy_route_decider
// Dimension-order (X then Y) route decision for one node of a 2D mesh or
// torus, with hop-limit drop, hop count update and hop distance report.
// ----------------------------------------------------------------------------
// Channel  Role    Payload  Content
// cfg      sink    cfg_t    register index and write data
// req      sink    req_t    req_type, dest_id, hops_taken
// rsp      source  rsp_t    action, new_hop_count, hop_distance
//
// A new header is taken in every cycle unless a stall backs up to the input;
// each result passes the input stage, the divider stages and the route stages.
// The divider is pipelined, four quotient bits per stage.
// Reset clears all stage valid bits and loads the register reset values.
// A stalled result holds every stage that is full; empty stages still fill.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_torus_xy_route_decider #(
	parameter int unsigned NODE_ID_BITS = 16,
	parameter int unsigned DIM_BITS     = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	mtxr_stream_if.sink   cfg,
	mtxr_stream_if.sink   req,
	mtxr_stream_if.source rsp
);

	localparam int unsigned ID_W = (NODE_ID_BITS < mtxr_pkg::ID_BITS) ?
		NODE_ID_BITS : mtxr_pkg::ID_BITS;
	localparam int unsigned GW      = mtxr_pkg::GRID_BITS;
	localparam int unsigned STEP    = mtxr_pkg::DIV_STEPS_PER_STAGE;
	localparam int unsigned NUM_DIV = (ID_W + STEP - 1) / STEP;
	localparam logic [31:0] MAX_DIM = 32'(1) << DIM_BITS;

	logic [mtxr_pkg::ID_BITS-1:0]  self_node_q;
	logic [GW-1:0]                 grid_width_q;
	logic [GW-1:0]                 grid_height_q;
	logic                          torus_mode_q;
	logic [mtxr_pkg::HOP_BITS-1:0] hop_limit_q;

	logic [GW-1:0] width_c, height_c;

	logic            v_s1;
	logic [ID_W-1:0] self_s1, dest_s1;
	mtxr_pkg::side_t side_s1, side_d;
	logic            s1_dn_ready;
	logic            arrived, drop;

	logic [NUM_DIV:0] div_valid, div_ready;
	logic [GW-1:0]    div_self_rem [NUM_DIV+1];
	logic [ID_W-1:0]  div_self_quo [NUM_DIV+1];
	logic [GW-1:0]    div_dest_rem [NUM_DIV+1];
	logic [ID_W-1:0]  div_dest_quo [NUM_DIV+1];
	mtxr_pkg::side_t  div_side     [NUM_DIV+1];

	function automatic logic [GW-1:0] clamp_dim(input logic [GW-1:0] v);
		logic [GW-1:0] r;
		r = v;
		if (v == '0) begin
			r = GW'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = MAX_DIM[GW-1:0];
		end
		return r;
	endfunction

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_node_q   <= mtxr_pkg::SELF_NODE_RESET;
			grid_width_q  <= mtxr_pkg::GRID_WIDTH_RESET;
			grid_height_q <= mtxr_pkg::GRID_HEIGHT_RESET;
			torus_mode_q  <= mtxr_pkg::TORUS_MODE_RESET;
			hop_limit_q   <= mtxr_pkg::HOP_LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.payload.index)
				mtxr_pkg::REG_SELF_NODE: begin
					self_node_q <= cfg.payload.data[mtxr_pkg::ID_BITS-1:0];
				end
				mtxr_pkg::REG_GRID_WIDTH: begin
					grid_width_q <= cfg.payload.data[GW-1:0];
				end
				mtxr_pkg::REG_GRID_HEIGHT: begin
					grid_height_q <= cfg.payload.data[GW-1:0];
				end
				mtxr_pkg::REG_TORUS_MODE: begin
					torus_mode_q <= cfg.payload.data[0];
				end
				mtxr_pkg::REG_HOP_LIMIT: begin
					hop_limit_q <= cfg.payload.data[mtxr_pkg::HOP_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign width_c  = clamp_dim(grid_width_q);
	assign height_c = clamp_dim(grid_height_q);

	always_comb begin
		arrived          = req.payload.req_type;
		drop             = arrived && (req.payload.hops_taken >= hop_limit_q);
		side_d.drop_hops = drop;
		side_d.is_local  = (req.payload.dest_id[ID_W-1:0] == self_node_q[ID_W-1:0]);
		if (arrived && !drop && (req.payload.hops_taken != '1)) begin
			side_d.new_hops = req.payload.hops_taken + mtxr_pkg::HOP_BITS'(1);
		end else begin
			side_d.new_hops = req.payload.hops_taken;
		end
	end

	assign req.ready = !v_s1 || s1_dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			dest_s1 <= req.payload.dest_id[ID_W-1:0];
			self_s1 <= self_node_q[ID_W-1:0];
			side_s1 <= side_d;
		end
	end

	assign div_valid[0]    = v_s1;
	assign s1_dn_ready     = div_ready[0];
	assign div_self_rem[0] = '0;
	assign div_self_quo[0] = self_s1;
	assign div_dest_rem[0] = '0;
	assign div_dest_quo[0] = dest_s1;
	assign div_side[0]     = side_s1;

	for (genvar k = 0; k < int'(NUM_DIV); k++) begin : g_div
		localparam int unsigned LEFT  = ID_W - k * STEP;
		localparam int unsigned STEPS = (LEFT < STEP) ? LEFT : STEP;

		mtxr_div_stage #(
			.ID_W   (ID_W),
			.GRID_W (GW),
			.STEPS  (STEPS)
		) u_stage (
			.clk         (clk),
			.arst_n      (arst_n),
			.divisor     (width_c),
			.up_valid    (div_valid[k]),
			.up_ready    (div_ready[k]),
			.up_self_rem (div_self_rem[k]),
			.up_self_quo (div_self_quo[k]),
			.up_dest_rem (div_dest_rem[k]),
			.up_dest_quo (div_dest_quo[k]),
			.up_side     (div_side[k]),
			.dn_valid    (div_valid[k+1]),
			.dn_ready    (div_ready[k+1]),
			.dn_self_rem (div_self_rem[k+1]),
			.dn_self_quo (div_self_quo[k+1]),
			.dn_dest_rem (div_dest_rem[k+1]),
			.dn_dest_quo (div_dest_quo[k+1]),
			.dn_side     (div_side[k+1])
		);
	end

	mtxr_route #(
		.ID_W   (ID_W),
		.GRID_W (GW)
	) u_route (
		.clk      (clk),
		.arst_n   (arst_n),
		.width    (width_c),
		.height   (height_c),
		.torus    (torus_mode_q),
		.up_valid (div_valid[NUM_DIV]),
		.up_ready (div_ready[NUM_DIV]),
		.self_rem (div_self_rem[NUM_DIV]),
		.self_quo (div_self_quo[NUM_DIV]),
		.dest_rem (div_dest_rem[NUM_DIV]),
		.dest_quo (div_dest_quo[NUM_DIV]),
		.side     (div_side[NUM_DIV]),
		.rsp      (rsp)
	);

	a_busy_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> v_s1)
		else $error("Input refused while the input stage is empty.");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s1_dn_ready |=> v_s1 && $stable(dest_s1) && $stable(side_s1))
		else $error("Input stage changed during a stall.");

	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> v_s1)
		else $error("Transfer in did not fill the input stage.");

endmodule

`default_nettype wire
